### hdl/range_kth_smallest_persistent_tree_core_macros.svh
// Assertion macros shared by the range k-th smallest core.
// No dependencies; included by the modules that carry assertions.
`ifndef RANGE_KTH_SMALLEST_PERSISTENT_TREE_CORE_MACROS_SVH
`define RANGE_KTH_SMALLEST_PERSISTENT_TREE_CORE_MACROS_SVH
// Check a property on every rising clock edge outside reset.
`define RKS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// Check a property including during reset.
`define RKS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);
`endif

### hdl/rks_pkg.sv
// Shared types and constants for the range k-th smallest core.
// No dependencies.
package rks_pkg;
    localparam int MAX_ITEMS  = 1024;
    localparam int VALUE_BITS = 16;
    localparam int NODE_POOL  = 17409;
    localparam int NODE_W     = 15;
    localparam int POS_W      = 11;
    localparam int CNT_W      = 11;
    localparam int LVL_W      = 5;
    localparam int BIT_W      = 4;
    localparam int ROOT_DEPTH = MAX_ITEMS + 1;
    localparam int ROOT_W     = 11;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_A_CHECK, S_A_ROOT, S_A_WR,
        S_Q_CHECK, S_Q_ROOT, S_Q_NODE, S_Q_CMP, S_OUT
    } state_t;

    typedef struct packed {
        logic root_rd;
        logic root_wr;
        logic rd_root;
        logic rd_left;
        logic rd_right;
        logic app_write;
        logic commit_append;
        logic q_step;
    } cmd_t;

    typedef struct packed {
        logic lvl_zero;
        logic lvl_one;
        logic go_left;
        logic full;
        logic bad;
    } sts_t;
endpackage

### hdl/rks_ctrl.sv
// Controller state machine for the range k-th smallest core.
// Uses rks_pkg and the shared assertion macros.
`include "range_kth_smallest_persistent_tree_core_macros.svh"
module rks_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_fire,
    input  logic           in_mode,
    input  rks_pkg::sts_t  sts,
    input  logic           out_free,
    output logic           busy,
    output logic           out_load,
    output logic           out_err,
    output rks_pkg::cmd_t  cmd
);
    rks_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rks_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        out_load   = 1'b0;
        out_err    = 1'b0;
        busy       = (state_reg != rks_pkg::S_IDLE);
        unique case (state_reg)
            rks_pkg::S_IDLE: begin
                if (in_fire) begin
                    state_next = in_mode ? rks_pkg::S_Q_CHECK : rks_pkg::S_A_CHECK;
                end
            end
            rks_pkg::S_A_CHECK: begin
                if (sts.full) begin
                    out_err    = 1'b1;
                    state_next = rks_pkg::S_OUT;
                end else begin
                    cmd.root_rd = 1'b1;
                    state_next  = rks_pkg::S_A_ROOT;
                end
            end
            rks_pkg::S_A_ROOT: begin
                cmd.rd_root = 1'b1;
                cmd.root_wr = 1'b1;
                state_next  = rks_pkg::S_A_WR;
            end
            rks_pkg::S_A_WR: begin
                cmd.app_write = 1'b1;
                if (sts.lvl_zero) begin
                    cmd.commit_append = 1'b1;
                    state_next        = rks_pkg::S_OUT;
                end
            end
            rks_pkg::S_Q_CHECK: begin
                if (sts.bad) begin
                    out_err    = 1'b1;
                    state_next = rks_pkg::S_OUT;
                end else begin
                    cmd.root_rd = 1'b1;
                    state_next  = rks_pkg::S_Q_ROOT;
                end
            end
            rks_pkg::S_Q_ROOT: begin
                cmd.rd_root = 1'b1;
                state_next  = rks_pkg::S_Q_NODE;
            end
            rks_pkg::S_Q_NODE: begin
                cmd.rd_left = 1'b1;
                state_next  = rks_pkg::S_Q_CMP;
            end
            rks_pkg::S_Q_CMP: begin
                cmd.q_step = 1'b1;
                if (sts.lvl_one) begin
                    state_next = rks_pkg::S_OUT;
                end else if (sts.go_left) begin
                    cmd.rd_left = 1'b1;
                end else begin
                    cmd.rd_right = 1'b1;
                    state_next   = rks_pkg::S_Q_NODE;
                end
            end
            rks_pkg::S_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = rks_pkg::S_IDLE;
                end
            end
            default: state_next = rks_pkg::S_IDLE;
        endcase
    end

    `RKS_ASSERT(a_accept_idle, in_fire |-> state_reg == rks_pkg::S_IDLE, "accept while busy")
    `RKS_ASSERT(a_load_from_out, out_load |-> state_reg == rks_pkg::S_OUT, "load outside output")
    `RKS_ASSERT(a_write_app, cmd.app_write |-> !cmd.q_step, "append and query overlap")
endmodule

### hdl/rks_dpath.sv
// Datapath for the range k-th smallest core: root table, node pool, descent.
// Uses rks_pkg; driven by rks_ctrl.
`include "range_kth_smallest_persistent_tree_core_macros.svh"
module rks_dpath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_fire,
    input  logic                             in_mode,
    input  logic [rks_pkg::VALUE_BITS-1:0]   in_value,
    input  logic [rks_pkg::POS_W-1:0]        in_left,
    input  logic [rks_pkg::POS_W-1:0]        in_right,
    input  logic [rks_pkg::POS_W-1:0]        in_k,
    input  rks_pkg::cmd_t                    cmd,
    input  logic                             out_err,
    output rks_pkg::sts_t                    sts,
    output logic [rks_pkg::VALUE_BITS-1:0]   res_answer,
    output logic [1:0]                       res_status
);
    localparam int NW = rks_pkg::NODE_W;
    localparam int CW = rks_pkg::CNT_W;
    localparam int PW = rks_pkg::POS_W;
    localparam int LW = rks_pkg::LVL_W;
    localparam int BW = rks_pkg::BIT_W;
    localparam int RW = rks_pkg::ROOT_W;
    localparam int WW = 2*NW + CW;

    // Node pool: one word holds left, right and count.
    logic [WW-1:0] pool_mem [rks_pkg::NODE_POOL];
    logic [NW-1:0] root_mem [rks_pkg::ROOT_DEPTH];

    logic [NW-1:0] free_reg, free_next;
    logic [PW-1:0] items_reg, items_next;
    logic          mode_reg;
    logic [rks_pkg::VALUE_BITS-1:0] val_reg, ans_reg;
    logic [PW-1:0] lpos_reg, rpos_reg, k_reg;
    logic [LW-1:0] lvl_reg;
    logic [BW-1:0] bit_idx;
    logic          bit_sel;
    logic [RW-1:0] root_ra, root_rb;
    logic [NW-1:0] root_a_raw, root_b_raw, root_qa, root_qb;
    logic          root_a_zero, root_b_zero;
    logic [NW-1:0] addr_a, addr_b;
    logic [WW-1:0] pool_a_raw, pool_b_raw, wr_data;
    logic          pool_a_zero, pool_b_zero;
    logic [NW-1:0] qa_l, qa_r, qb_l, qb_r, link_new, rr_reg, rl_reg;
    logic [CW-1:0] qa_c, qb_c, x;
    logic          go_left;
    logic [PW:0]   span;

    // Root table: two read ports, write on append; entry zero reads as node zero.
    assign root_ra = mode_reg ? rpos_reg : items_reg;
    assign root_rb = lpos_reg - PW'(1);
    always_ff @(posedge aclk) begin
        if (cmd.root_wr) root_mem[items_reg + PW'(1)] <= free_reg;
        if (cmd.root_rd) begin
            root_a_raw  <= root_mem[root_ra];
            root_b_raw  <= root_mem[root_rb];
            root_a_zero <= (root_ra == '0);
            root_b_zero <= (root_rb == '0);
        end
    end
    assign root_qa = root_a_zero ? '0 : root_a_raw;
    assign root_qb = root_b_zero ? '0 : root_b_raw;

    // Node pool: port A follows the right version, port B the left one.
    assign bit_idx  = BW'(lvl_reg - LW'(1));
    assign bit_sel  = val_reg[bit_idx];
    assign link_new = free_reg + NW'(1);

    always_comb begin
        addr_a = '0;
        addr_b = '0;
        if (cmd.rd_root) begin
            addr_a = root_qa;
            addr_b = mode_reg ? root_qb : '0;
        end else if (cmd.rd_left) begin
            addr_a = qa_l;
            addr_b = qb_l;
        end else if (cmd.rd_right) begin
            addr_a = rr_reg;
            addr_b = rl_reg;
        end else if (cmd.app_write) begin
            addr_a = bit_sel ? qa_r : qa_l;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.app_write) pool_mem[free_reg] <= wr_data;
        pool_a_raw  <= pool_mem[addr_a];
        pool_b_raw  <= pool_mem[addr_b];
        pool_a_zero <= (addr_a == '0);
        pool_b_zero <= (addr_b == '0);
    end

    // Node zero reads as empty; every other read is of a written node.
    assign qa_l = pool_a_zero ? '0 : pool_a_raw[WW-1 -: NW];
    assign qa_r = pool_a_zero ? '0 : pool_a_raw[NW+CW-1 -: NW];
    assign qa_c = pool_a_zero ? '0 : pool_a_raw[CW-1:0];
    assign qb_l = pool_b_zero ? '0 : pool_b_raw[WW-1 -: NW];
    assign qb_r = pool_b_zero ? '0 : pool_b_raw[NW+CW-1 -: NW];
    assign qb_c = pool_b_zero ? '0 : pool_b_raw[CW-1:0];

    // Copy of the old node with one more count; relink the path child above leaf level.
    always_comb begin
        if (lvl_reg == '0) begin
            wr_data = {qa_l, qa_r, qa_c + CW'(1)};
        end else if (bit_sel) begin
            wr_data = {qa_l, link_new, qa_c + CW'(1)};
        end else begin
            wr_data = {link_new, qa_r, qa_c + CW'(1)};
        end
    end

    assign x       = qa_c - qb_c;
    assign go_left = (x >= k_reg);

    // Status for the controller.
    assign span = {1'b0, rpos_reg} - {1'b0, lpos_reg} + (PW+1)'(1);
    always_comb begin
        sts.lvl_zero = (lvl_reg == '0);
        sts.lvl_one  = (lvl_reg == LW'(1));
        sts.go_left  = go_left;
        sts.full     = (items_reg >= PW'(rks_pkg::MAX_ITEMS)) ||
                       ({1'b0, free_reg} + (NW+1)'(rks_pkg::VALUE_BITS + 1) >
                        (NW+1)'(rks_pkg::NODE_POOL));
        sts.bad      = (lpos_reg == '0) || (lpos_reg > rpos_reg) ||
                       (rpos_reg > items_reg) || (k_reg == '0) ||
                       ({1'b0, k_reg} > span);
    end

    // Control registers.
    always_comb begin
        free_next  = free_reg;
        items_next = items_reg;
        if (cmd.app_write) free_next = free_reg + NW'(1);
        if (cmd.commit_append) items_next = items_reg + PW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_reg  <= NW'(1);
            items_reg <= '0;
        end else begin
            free_reg  <= free_next;
            items_reg <= items_next;
        end
    end

    // Descent registers.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            mode_reg <= in_mode;
            val_reg  <= in_value;
            lpos_reg <= in_left;
            rpos_reg <= in_right;
            k_reg    <= in_k;
            ans_reg  <= '0;
            lvl_reg  <= LW'(rks_pkg::VALUE_BITS);
        end
        if ((cmd.app_write || cmd.q_step) && lvl_reg != '0) begin
            lvl_reg <= lvl_reg - LW'(1);
        end
        if (cmd.rd_left) begin
            rr_reg <= qa_r;
            rl_reg <= qb_r;
        end
        if (cmd.q_step && !go_left) begin
            k_reg            <= k_reg - x;
            ans_reg[bit_idx] <= 1'b1;
        end
    end

    assign res_answer = (out_err || !mode_reg) ? '0 : ans_reg;
    assign res_status = out_err ? (mode_reg ? rks_pkg::ST_BAD : rks_pkg::ST_FULL)
                                : rks_pkg::ST_OK;

    `RKS_ASSERT(a_free_grows, cmd.app_write |=> free_reg == $past(free_reg) + 1'b1, "free ptr")
    `RKS_ASSERT(a_items_cap, items_reg <= PW'(rks_pkg::MAX_ITEMS), "items over capacity")
    `RKS_ASSERT_ALWAYS(a_reset_free, !aresetn |=> free_reg == NW'(1), "free ptr reset")
endmodule

### hdl/range_kth_smallest_persistent_tree_core.sv
// Top level of the range k-th smallest core over a persistent count tree.
// Uses rks_pkg, rks_ctrl and rks_dpath.
//
// Usage: one input word on s_axis per item; one result word on m_axis per item.
// Append (mode 0) copies the root-to-leaf path of the latest version into the
// node pool, one node per cycle, in these steps: check, root read,
// VALUE_BITS + 1 node writes, output load.
// Query (mode 1) walks versions right and left-1 together on two pool read
// ports: a level going left takes the compare state alone, a level going right
// the node read state and then the compare state.
// A bad query or a full store goes from the check state straight to output.
// One item is in work at a time; s_axis_tready is high only when idle, so
// the next item is taken only after the last has been loaded for output.
// Reset clears the item count and the free-node pointer; the pool and root
// table need no clearing pass because node zero and root zero read as empty
// and every other link points to a written node.
// A stalled receiver holds the result word; the next item may still be taken
// and worked, then waits at the end until the output register is free.
module range_kth_smallest_persistent_tree_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: mode[0], value[16:1], left_pos[27:17], right_pos[38:28], rank_k[49:39]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: answer[15:0], status[17:16]
    output logic [23:0] m_axis_tdata
);
    rks_pkg::cmd_t cmd;
    rks_pkg::sts_t sts;
    logic busy, out_load, out_err, in_fire, out_free;
    logic [15:0] res_answer;
    logic [1:0]  res_status;
    logic        err_reg;
    logic        out_valid_reg;
    logic [17:0] out_data_reg;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !busy;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Hold an error flag from the check state until the output state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_reg <= 1'b0;
        end else if (in_fire) begin
            err_reg <= 1'b0;
        end else if (out_err) begin
            err_reg <= 1'b1;
        end
    end

    rks_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire),
        .in_mode(s_axis_tdata[0]), .sts(sts), .out_free(out_free),
        .busy(busy), .out_load(out_load), .out_err(out_err), .cmd(cmd)
    );

    rks_dpath u_dpath (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire),
        .in_mode(s_axis_tdata[0]), .in_value(s_axis_tdata[16:1]),
        .in_left(s_axis_tdata[27:17]), .in_right(s_axis_tdata[38:28]),
        .in_k(s_axis_tdata[49:39]), .cmd(cmd), .out_err(err_reg),
        .sts(sts), .res_answer(res_answer), .res_status(res_status)
    );

    // Output register: load on completion, drop when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (out_load) out_data_reg <= {res_status, res_answer};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_data_reg};
endmodule

### verif/tb_top.sv
// Self-checking testbench for range_kth_smallest_persistent_tree_core.
// Predicts each result word with a local persistent count tree; depends on rks_pkg.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WDOG_LIMIT = 20000;
    localparam int ROOTS = rks_pkg::MAX_ITEMS + 1;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] answer;
    } result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    range_kth_smallest_persistent_tree_core DUT (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Local copy of the tree state
    int unsigned tree_root [ROOTS];
    int unsigned tree_lo   [rks_pkg::NODE_POOL];
    int unsigned tree_hi   [rks_pkg::NODE_POOL];
    int unsigned tree_cnt  [rks_pkg::NODE_POOL];
    int unsigned free_node;
    int unsigned stored_cnt;

    result_t expected_words[$];
    int      mismatch_cnt = 0;
    int      idle_cycles  = 0;
    bit      rx_stall_on  = 1'b1;

    function automatic int unsigned grab_node(int unsigned src);
        int unsigned n;
        n = free_node;
        free_node++;
        tree_lo[n]  = tree_lo[src];
        tree_hi[n]  = tree_hi[src];
        tree_cnt[n] = tree_cnt[src] + 1;
        return n;
    endfunction

    // Work out the result word of one item and advance the local tree
    function automatic result_t predict_kth(logic mode, logic [15:0] value,
                                            int unsigned lp, int unsigned rp,
                                            int unsigned k);
        result_t r;
        int unsigned prev, cur, oc, nc, rn, ln, diff;
        r = '0;
        if (!mode) begin
            if (stored_cnt >= rks_pkg::MAX_ITEMS ||
                free_node + rks_pkg::VALUE_BITS + 1 > rks_pkg::NODE_POOL) begin
                r.status = rks_pkg::ST_FULL;
            end else begin
                prev = tree_root[stored_cnt];
                cur  = grab_node(prev);
                tree_root[stored_cnt + 1] = cur;
                for (int b = rks_pkg::VALUE_BITS - 1; b >= 0; b--) begin
                    if (!value[b]) begin
                        oc = tree_lo[prev];
                        nc = grab_node(oc);
                        tree_lo[cur] = nc;
                    end else begin
                        oc = tree_hi[prev];
                        nc = grab_node(oc);
                        tree_hi[cur] = nc;
                    end
                    prev = oc;
                    cur  = nc;
                end
                stored_cnt++;
            end
        end else if (lp == 0 || lp > rp || rp > stored_cnt || k == 0 || k > rp - lp + 1) begin
            r.status = rks_pkg::ST_BAD;
        end else begin
            rn = tree_root[rp];
            ln = tree_root[lp - 1];
            for (int b = rks_pkg::VALUE_BITS - 1; b >= 0; b--) begin
                diff = tree_cnt[tree_lo[rn]] - tree_cnt[tree_lo[ln]];
                if (diff >= k) begin
                    rn = tree_lo[rn];
                    ln = tree_lo[ln];
                end else begin
                    k -= diff;
                    r.answer[b] = 1'b1;
                    rn = tree_hi[rn];
                    ln = tree_hi[ln];
                end
            end
        end
        return r;
    endfunction

    function automatic int pick_gap();
        if (!rx_stall_on) return 0;
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one input word at a falling edge and hold it until taken;
    // tvalid stays up until the next word or an idle gap replaces it
    task automatic send_word(logic mode, logic [15:0] value, logic [10:0] lp,
                             logic [10:0] rp, logic [10:0] k);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tdata  <= {6'b0, k, rp, lp, value, mode};
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        expected_words.push_back(predict_kth(mode, value, 32'(lp), 32'(rp), 32'(k)));
        @(negedge aclk);
    endtask

    task automatic send_append(logic [15:0] v);
        send_word(1'b0, v, 11'($urandom), 11'($urandom), 11'($urandom));
    endtask

    task automatic send_query(logic [10:0] lp, logic [10:0] rp, logic [10:0] k);
        send_word(1'b1, 16'($urandom), lp, rp, k);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
        while (expected_words.size() != 0) @(negedge aclk);
    endtask

    // Receiver: random stalls, compare each word with the oldest expectation
    initial begin
        result_t got, want;
        forever begin
            @(negedge aclk);
            m_axis_tready <= (pick_gap() == 0);
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[17:0];
                if (expected_words.size() == 0) begin
                    $error("unexpected result word answer=%0d status=%0d",
                           got.answer, got.status);
                    mismatch_cnt++;
                end else begin
                    want = expected_words.pop_front();
                    if (got.answer !== want.answer) begin
                        $error("answer: expected %0d, actual %0d", want.answer, got.answer);
                        mismatch_cnt++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    // Watchdog: count cycles with no word moving on either side
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Directed: bad queries on an empty store, extreme values, edge ranks
    task automatic test_directed();
        send_query(11'd1, 11'd1, 11'd1);
        send_query(11'd0, 11'd0, 11'd0);
        send_append(16'h0000);
        send_append(16'hFFFF);
        send_append(16'h8000);
        send_append(16'h7FFF);
        send_append(16'h0001);
        send_query(11'd1, 11'd5, 11'd1);
        send_query(11'd1, 11'd5, 11'd5);
        send_query(11'd2, 11'd4, 11'd2);
        send_query(11'd3, 11'd3, 11'd1);
        send_query(11'd0, 11'd3, 11'd1);
        send_query(11'd4, 11'd3, 11'd1);
        send_query(11'd1, 11'd6, 11'd1);
        send_query(11'd1, 11'd5, 11'd0);
        send_query(11'd2, 11'd5, 11'd5);
        send_query(11'h7FF, 11'h7FF, 11'h7FF);
    endtask

    // Mostly valid queries over the stored range, with some noise
    task automatic send_random_query();
        int unsigned n, lp, rp;
        n = stored_cnt;
        if (n == 0 || $urandom_range(0, 9) == 0) begin
            send_query(11'($urandom), 11'($urandom), 11'($urandom));
        end else begin
            rp = $urandom_range(1, n);
            lp = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, rp);
            send_query(11'(lp), 11'(rp), 11'($urandom_range(1, rp - lp + 1)));
        end
    endtask

    task automatic test_random_mix();
        logic [15:0] v;
        for (int i = 0; i < 40; i++) begin
            if ($urandom_range(0, 1) == 0) begin
                // small value set gives duplicates; else full-range values
                v = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
                send_append(v);
            end else begin
                send_random_query();
            end
            // hold off once until every expected word has come back
            if (i == 20) drain();
        end
    endtask

    // Fill the store to its limit, then appends must report a full store; queries follow
    task automatic test_fill_store();
        while (stored_cnt < rks_pkg::MAX_ITEMS) send_append(16'($urandom));
        send_append(16'hFFFF);
        send_append(16'h0000);
        send_query(11'd1, 11'd1024, 11'd1024);
        send_query(11'd1, 11'd1024, 11'd1);
        send_query(11'd1, 11'd1025, 11'd1);
        rx_stall_on = 1'b0;
        for (int i = 0; i < 5; i++) send_random_query();
        rx_stall_on = 1'b1;
        for (int i = 0; i < 5; i++) send_random_query();
    endtask

    initial begin
        tree_root[0] = 0;
        tree_lo[0]   = 0;
        tree_hi[0]   = 0;
        tree_cnt[0]  = 0;
        free_node    = 1;
        stored_cnt   = 0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_random_mix();
        test_fill_store();
        drain();
        repeat (100) @(negedge aclk);
        if (mismatch_cnt == 0 && expected_words.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

### files.f
+incdir+hdl
hdl/rks_pkg.sv
hdl/rks_ctrl.sv
hdl/rks_dpath.sv
hdl/range_kth_smallest_persistent_tree_core.sv
verif/tb_top.sv
